### rtl/core/melody_string_tone_sequencer_core_assert.svh
// assertion macros for the melody tone sequencer core
// modules that include this need clk and rst_n in scope
`ifndef MELODY_STRING_TONE_SEQUENCER_CORE_ASSERT_SVH
`define MELODY_STRING_TONE_SEQUENCER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MSTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MSTS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define MSTS_ASSERT(label, prop, msg)
`define MSTS_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

### rtl/core/mstseq_pkg.sv
// shared types, constants and the note period table of the tone sequencer
// used by the front, queue, back and top level modules
package mstseq_pkg;

    localparam int DUR_W     = 12;
    localparam int PERIOD_W  = 12;
    localparam int PAUSE_W   = 5;
    localparam int ELAPSED_W = 22;
    localparam int UNIT_W    = 8;
    localparam int CHAR_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int US_PER_MS_DEFAULT = 1000;

    localparam logic [UNIT_W-1:0] UNIT_RESET    = 8'd200;
    localparam logic [DUR_W-1:0]  DEFAULT_RESET = 12'd400;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DURATION_UNIT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_DURATION = 1'd1;

    // item kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // song characters
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_G = 8'h47;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_G = 8'h67;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_UNDER   = 8'h5F;

    localparam logic [PAUSE_W-1:0] PAUSE_NONE  = 5'd0;
    localparam logic [PAUSE_W-1:0] PAUSE_SHORT = 5'd5;
    localparam logic [PAUSE_W-1:0] PAUSE_MID   = 5'd20;
    localparam logic [PAUSE_W-1:0] PAUSE_LONG  = 5'd30;

    localparam int NOTE_COUNT = 14;
    localparam logic [3:0] LOWER_BASE = 4'd7;
    localparam logic [PERIOD_W-1:0] PERIOD_TABLE [NOTE_COUNT] = '{
        12'd2272, 12'd2024, 12'd3816, 12'd3401, 12'd3030, 12'd2865, 12'd2551,
        12'd1136, 12'd1012, 12'd1912, 12'd1703, 12'd1517, 12'd1432, 12'd1275
    };

    // one classified item as it travels from front to back
    typedef struct packed {
        logic                kind;
        logic                is_zero;
        logic [PERIOD_W-1:0] period;
        logic [DUR_W-1:0]    dur_ms;
        logic [PAUSE_W-1:0]  pause;
    } item_t;

    function automatic logic [PERIOD_W-1:0] note_period(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] off;
        off = '0;
        note_period = '0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_G)
        begin
            off = c - CH_UPPER_A;
            note_period = PERIOD_TABLE[off[3:0]];
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_G)
        begin
            off = c - CH_LOWER_A;
            note_period = PERIOD_TABLE[off[3:0] + LOWER_BASE];
        end
    endfunction

    function automatic logic [PAUSE_W-1:0] pause_of(input logic [CHAR_W-1:0] c);
        case (c)
            CH_PLUS:  pause_of = PAUSE_NONE;
            CH_DOT:   pause_of = PAUSE_MID;
            CH_UNDER: pause_of = PAUSE_LONG;
            default:  pause_of = PAUSE_SHORT;
        endcase
    endfunction

endpackage

### rtl/core/mstseq_front.sv
// front end: holds the config registers and classifies each incoming beat
// depends on mstseq_pkg
module mstseq_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mstseq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mstseq_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                in_kind,
    input  logic [mstseq_pkg::CHAR_W-1:0]       in_char,
    output mstseq_pkg::item_t                   item
);

    logic [mstseq_pkg::UNIT_W-1:0] unit_reg;
    logic [mstseq_pkg::DUR_W-1:0]  default_reg;
    logic [mstseq_pkg::CHAR_W-1:0] digit;
    logic [mstseq_pkg::DUR_W-1:0]  digit_dur;
    logic                          is_digit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg    <= mstseq_pkg::UNIT_RESET;
            default_reg <= mstseq_pkg::DEFAULT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mstseq_pkg::REG_DURATION_UNIT:
                    unit_reg <= cfg_data[mstseq_pkg::UNIT_W-1:0];
                mstseq_pkg::REG_DEFAULT_DURATION:
                    default_reg <= cfg_data[mstseq_pkg::DUR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign is_digit  = (in_char >= mstseq_pkg::CH_DIGIT_0) && (in_char <= mstseq_pkg::CH_DIGIT_9);
    assign digit     = in_char - mstseq_pkg::CH_DIGIT_0;
    // 4 by 8 bit product always fits in 12 bits
    assign digit_dur = mstseq_pkg::DUR_W'(digit[3:0]) * mstseq_pkg::DUR_W'(unit_reg);

    always_comb
    begin
        item.kind    = in_kind;
        item.is_zero = (in_char == '0);
        item.period  = mstseq_pkg::note_period(in_char);
        item.dur_ms  = is_digit ? digit_dur : default_reg;
        item.pause   = mstseq_pkg::pause_of(in_char);
    end

endmodule

### rtl/core/mstseq_queue.sv
// short queue of classified beats between the front and back ends
// depends on mstseq_pkg
module mstseq_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mstseq_pkg::item_t push_item,
    output logic              full,
    output logic              q_valid,
    output mstseq_pkg::item_t q_item,
    input  logic              pop
);

    localparam int PTR_W = $clog2(mstseq_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mstseq_pkg::QUEUE_DEPTH + 1);

    mstseq_pkg::item_t  slots [mstseq_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full    = (count_reg == CNT_W'(mstseq_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/core/mstseq_back.sv
// back end: runs the group, tone, rest and pause state and registers each result
// depends on mstseq_pkg and the assertion macro header
`include "melody_string_tone_sequencer_core_assert.svh"

module mstseq_back #(
    parameter int US_PER_MS = mstseq_pkg::US_PER_MS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  mstseq_pkg::item_t q_item,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata
);

    localparam int PROD_W = mstseq_pkg::DUR_W + $clog2(US_PER_MS + 1);
    localparam int EW     = mstseq_pkg::ELAPSED_W;
    localparam int PW     = mstseq_pkg::PERIOD_W;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_TONE  = 2'd1,
        MODE_REST  = 2'd2,
        MODE_PAUSE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_NOTE  = 2'd0,
        PH_DUR   = 2'd1,
        PH_PAUSE = 2'd2
    } phase_t;

    mode_t                           mode_reg, mode_next;
    phase_t                          phase_reg, phase_next;
    logic [PW-1:0]                   period_reg, period_next;
    logic [EW-1:0]                   target_reg, target_next;
    logic [mstseq_pkg::PAUSE_W-1:0]  pause_reg, pause_next;
    logic [EW-1:0]                   elapsed_reg, elapsed_next;
    logic [PW-1:0]                   half_reg, half_next;
    logic                            level_reg, level_next;
    logic                            out_valid_reg;
    logic [2:0]                      out_data_reg;

    logic [PROD_W-1:0]               dur_us;
    logic [PW-1:0]                   half_inc;
    logic [PW-1:0]                   half_period;
    logic [EW-1:0]                   elapsed_inc;
    logic [EW-1:0]                   elapsed_sum;
    logic                            end_play;
    logic                            dropped;

    assign pop         = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = {5'd0, out_data_reg};

    assign dur_us      = PROD_W'(q_item.dur_ms * PROD_W'(US_PER_MS));
    assign half_inc    = half_reg + 1'b1;
    assign half_period = period_reg >> 1;
    assign elapsed_inc = elapsed_reg + 1'b1;
    assign elapsed_sum = elapsed_reg + EW'(period_reg);

    always_comb
    begin
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        period_next  = period_reg;
        target_next  = target_reg;
        pause_next   = pause_reg;
        elapsed_next = elapsed_reg;
        half_next    = half_reg;
        level_next   = level_reg;
        end_play     = 1'b0;
        dropped      = 1'b0;
        if (pop)
        begin
            if (q_item.kind == mstseq_pkg::KIND_TICK)
            begin
                unique case (mode_reg)
                    MODE_TONE:
                    begin
                        if (half_inc >= half_period)
                        begin
                            half_next = '0;
                            if (level_reg)
                                level_next = 1'b0;
                            else if (elapsed_sum < target_reg)
                            begin
                                elapsed_next = elapsed_sum;
                                level_next   = 1'b1;
                            end
                            else
                                end_play = 1'b1;
                        end
                        else
                            half_next = half_inc;
                    end
                    MODE_REST:
                    begin
                        if (elapsed_inc >= target_reg)
                            end_play = 1'b1;
                        else
                            elapsed_next = elapsed_inc;
                    end
                    MODE_PAUSE:
                    begin
                        if (elapsed_inc >= EW'(pause_reg))
                        begin
                            mode_next    = MODE_IDLE;
                            elapsed_next = '0;
                        end
                        else
                            elapsed_next = elapsed_inc;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (mode_reg != MODE_IDLE)
                dropped = 1'b1;
            else if (q_item.is_zero)
                phase_next = PH_NOTE;
            else
            begin
                unique case (phase_reg)
                    PH_NOTE:
                    begin
                        period_next = q_item.period;
                        phase_next  = PH_DUR;
                    end
                    PH_DUR:
                    begin
                        target_next = EW'(dur_us);
                        phase_next  = PH_PAUSE;
                    end
                    PH_PAUSE:
                    begin
                        pause_next   = q_item.pause;
                        phase_next   = PH_NOTE;
                        elapsed_next = '0;
                        half_next    = '0;
                        if (target_reg == '0)
                            end_play = 1'b1;
                        else if (period_reg != '0)
                        begin
                            mode_next  = MODE_TONE;
                            level_next = 1'b1;
                        end
                        else
                        begin
                            mode_next  = MODE_REST;
                            level_next = 1'b0;
                        end
                    end
                    default:
                        phase_next = PH_NOTE;
                endcase
            end
            // tone or rest done, or zero duration: go quiet, then pause or idle
            if (end_play)
            begin
                level_next   = 1'b0;
                half_next    = '0;
                elapsed_next = '0;
                mode_next    = (pause_next == '0) ? MODE_IDLE : MODE_PAUSE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            phase_reg     <= PH_NOTE;
            period_reg    <= '0;
            target_reg    <= '0;
            pause_reg     <= '0;
            elapsed_reg   <= '0;
            half_reg      <= '0;
            level_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
            period_reg  <= period_next;
            target_reg  <= target_next;
            pause_reg   <= pause_next;
            elapsed_reg <= elapsed_next;
            half_reg    <= half_next;
            level_reg   <= level_next;
            if (pop)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_data_reg <= {dropped, (mode_next != MODE_IDLE), level_next};
    end

    `MSTS_ASSERT_IMP(a_level_only_in_tone, level_reg, mode_reg == MODE_TONE, "buzzer high outside a tone")
    `MSTS_ASSERT_IMP(a_half_in_range, mode_reg == MODE_TONE, half_reg < half_period, "half counter overran")
    `MSTS_ASSERT_IMP(a_group_closed_while_busy, mode_reg != MODE_IDLE, phase_reg == PH_NOTE, "group open while playing")
    `MSTS_ASSERT_IMP(a_pause_in_range, mode_reg == MODE_PAUSE, elapsed_reg < EW'(pause_reg), "pause overran")

endmodule

### rtl/core/melody_string_tone_sequencer_core.sv
// throughput: one beat per cycle, character or tick, while the queue is not full; the back
// end retires one per clock while the result register is empty or m_tready is high
// a four entry queue sits between the classifier and the player, and a result register
// on m_tdata lets input beats keep coming while m_tready is low until the queue fills
// reset (rst_n low, async): config back to 200 ms unit and 400 ms default, player idle,
// buzzer low, queue and result register empty; no clearing pass
module melody_string_tone_sequencer_core #(
    parameter int US_PER_MS = mstseq_pkg::US_PER_MS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] song_char
    input  logic                               s_tuser,   // [0] kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [0] buzzer_level, [1] busy_res,
                                                          // [2] char_dropped, [7:3] zero
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mstseq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mstseq_pkg::CFG_DATA_W-1:0]  cfg_data
);

    mstseq_pkg::item_t front_item;
    mstseq_pkg::item_t q_item;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic              push;

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    mstseq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_kind   (s_tuser),
        .in_char   (s_tdata),
        .item      (front_item)
    );

    mstseq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop)
    );

    mstseq_back #(
        .US_PER_MS (US_PER_MS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
